/* hw/rtl/fixed_partition_fit_allocator_assert.svh */
// assertion macros for the fixed partition fit allocator
// no dependencies; taken in by the top level with an include
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FPFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpfa assertion failed");

// next-cycle implication, disabled during reset
`define FPFA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpfa assertion failed");

`endif

/* hw/rtl/fpfa_pkg.sv */
// shared types and constants for the fixed partition fit allocator
// no dependencies
package fpfa_pkg;

  // default sizing
  localparam int NUM_PARTITIONS_DEF = 16;
  localparam int SIZE_WIDTH_DEF     = 16;

  // field widths of the transactions
  localparam int FIELD_IDX_W  = 4;
  localparam int FIELD_SIZE_W = 16;
  localparam int PARTS_W      = 5;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE = 1'd1;
  localparam logic [PARTS_W-1:0]   PARTS_RESET      = 5'd16;

  // fit modes
  localparam logic FIT_BEST  = 1'b0;
  localparam logic FIT_FIRST = 1'b1;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [FIELD_IDX_W-1:0]  partition_index;
    logic [FIELD_SIZE_W-1:0] partition_size;
    logic [FIELD_SIZE_W-1:0] request_size;
    logic                    last_request;
  } req_item_t;

  typedef struct packed {
    logic                    granted;
    logic [FIELD_IDX_W-1:0]  granted_index;
    logic [FIELD_SIZE_W-1:0] granted_size;
  } rsp_item_t;

  // control from the sequencer to the fit scan unit
  typedef struct packed {
    logic clear;
    logic sample;
    logic take_first;
  } scan_ctrl_t;

endpackage

/* hw/rtl/fpfa_size_mem.sv */
// partition size memory: one write port, one read port, registered read data
// depends on nothing
module fpfa_size_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/fpfa_fit_scan.sv */
// fit scan unit: one candidate partition a cycle, keeps the best so far
// depends on fpfa_pkg
module fpfa_fit_scan #(
  parameter int SIZE_WIDTH = 16,
  parameter int IDX_W      = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fpfa_pkg::scan_ctrl_t   ctrl,
  input  logic [SIZE_WIDTH-1:0]  req_size,
  input  logic [SIZE_WIDTH-1:0]  entry_size,
  input  logic                   entry_occ,
  input  logic [IDX_W-1:0]       entry_idx,
  output logic                   found,
  output logic [IDX_W-1:0]       pick_idx,
  output logic [SIZE_WIDTH-1:0]  pick_size
);

  logic [SIZE_WIDTH-1:0] best_left;
  logic [SIZE_WIDTH-1:0] left;
  logic                  fits;
  logic                  take;

  // candidate check; strict less keeps ties on the lowest index
  assign fits = !entry_occ && (entry_size >= req_size);
  assign left = entry_size - req_size;
  assign take = ctrl.sample && fits &&
                (!found || (!ctrl.take_first && (left < best_left)));

  // found flag
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  // best candidate so far
  always_ff @(posedge clk) begin
    if (take) begin
      pick_idx  <= entry_idx;
      pick_size <= entry_size;
      best_left <= left;
    end
  end

endmodule

/* hw/rtl/fixed_partition_fit_allocator.sv */
// top level of the fixed partition fit allocator: sequencer, occupancy, output register
// depends on fpfa_pkg, fpfa_size_mem, fpfa_fit_scan and the assertion header
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//  req     | in        | req_valid / req_stall  | req_item (req_item_t)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_item (rsp_item_t)
//
// a load transaction writes the size memory when accepted; an allocate transaction reads
// the sizes in ST_SCAN, then waits in ST_DONE for the output register, and the next
// request is taken after that; count is the partitions in use, one size memory read per cycle.
// reset clears occupancy and the control and configuration registers; sizes are undefined until loaded.
// a result waits in the output register; a new request is taken meanwhile, and
// the next result waits for the register to empty.
`include "fixed_partition_fit_allocator_assert.svh"

module fixed_partition_fit_allocator #(
  parameter int NUM_PARTITIONS = fpfa_pkg::NUM_PARTITIONS_DEF,
  parameter int SIZE_WIDTH     = fpfa_pkg::SIZE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  fpfa_pkg::req_item_t             req_item,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output fpfa_pkg::rsp_item_t             rsp_item
);

  localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  logic                         fit_mode;
  logic [fpfa_pkg::PARTS_W-1:0] parts_in_use;
  logic [NUM_PARTITIONS-1:0]    occ;

  logic [SIZE_WIDTH-1:0] req_size;
  logic                  last_flag;
  logic                  take_first;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      issue;
  logic [CNT_W-1:0]      active_count;
  logic                  issue_more;
  logic                  issue_now;
  logic                  s_valid;
  logic [IDX_W-1:0]      s_idx;
  logic                  s_occ;

  logic                  req_accept;
  logic                  is_alloc;
  logic                  load_ok;
  logic [IDX_W-1:0]      load_addr;
  logic                  done_fire;

  logic [SIZE_WIDTH-1:0] mem_rdata;
  fpfa_pkg::scan_ctrl_t  scan_ctrl;
  logic                  found;
  logic [IDX_W-1:0]      pick_idx;
  logic [SIZE_WIDTH-1:0] pick_size;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode     <= fpfa_pkg::FIT_BEST;
      parts_in_use <= fpfa_pkg::PARTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fpfa_pkg::CFG_FIT_MODE:     fit_mode     <= cfg_data[0];
        fpfa_pkg::CFG_PARTS_IN_USE: parts_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // request decode
  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && (state == ST_IDLE);
  assign is_alloc   = req_accept && (req_item.cmd == fpfa_pkg::CMD_ALLOC);
  assign load_ok    = req_accept && (req_item.cmd == fpfa_pkg::CMD_LOAD) &&
                      (32'(req_item.partition_index) < NUM_PARTITIONS);
  assign load_addr  = IDX_W'(req_item.partition_index);

  // partition count saturates at the memory depth
  assign active_count = (32'(parts_in_use) > NUM_PARTITIONS) ?
                        CNT_W'(NUM_PARTITIONS) : CNT_W'(parts_in_use);

  assign issue_more = (issue < count);
  assign issue_now  = (state == ST_SCAN) && issue_more;
  assign done_fire  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (is_alloc) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue_more && !s_valid) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (done_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      s_valid <= 1'b0;
    end else begin
      state   <= state_next;
      s_valid <= issue_now;
    end
  end

  // allocate job registers and read issue
  always_ff @(posedge clk) begin
    if (is_alloc) begin
      req_size   <= SIZE_WIDTH'(req_item.request_size);
      last_flag  <= req_item.last_request;
      take_first <= (fit_mode == fpfa_pkg::FIT_FIRST);
      count      <= active_count;
      issue      <= '0;
    end else if (issue_now) begin
      issue <= issue + CNT_W'(1);
      s_idx <= issue[IDX_W-1:0];
      s_occ <= occ[issue[IDX_W-1:0]];
    end
  end

  // occupancy marks: a load frees its partition, a grant marks its pick, batch end clears them all
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (load_ok) begin
      occ[load_addr] <= 1'b0;
    end else if (done_fire) begin
      if (last_flag) begin
        occ <= '0;
      end else if (found) begin
        occ[pick_idx] <= 1'b1;
      end
    end
  end

  fpfa_size_mem #(
    .DEPTH (NUM_PARTITIONS),
    .WIDTH (SIZE_WIDTH),
    .AW    (IDX_W)
  ) u_size_mem (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_addr),
    .wdata (SIZE_WIDTH'(req_item.partition_size)),
    .re    (issue_now),
    .raddr (issue[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  assign scan_ctrl.clear      = is_alloc;
  assign scan_ctrl.sample     = s_valid;
  assign scan_ctrl.take_first = take_first;

  fpfa_fit_scan #(
    .SIZE_WIDTH (SIZE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_fit_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (scan_ctrl),
    .req_size   (req_size),
    .entry_size (mem_rdata),
    .entry_occ  (s_occ),
    .entry_idx  (s_idx),
    .found      (found),
    .pick_idx   (pick_idx),
    .pick_size  (pick_size)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      rsp_item.granted       <= found;
      rsp_item.granted_index <= found ? fpfa_pkg::FIELD_IDX_W'(pick_idx) : '0;
      rsp_item.granted_size  <= found ? fpfa_pkg::FIELD_SIZE_W'(pick_size) : '0;
    end
  end

  // checks
  `FPFA_ASSERT_IMP(a_no_grant_zero, clk, rst, rsp_valid && !rsp_item.granted, (rsp_item.granted_index == '0) && (rsp_item.granted_size == '0))
  `FPFA_ASSERT_IMP(a_sample_in_scan, clk, rst, s_valid, state == ST_SCAN)
  `FPFA_ASSERT_NXT(a_grant_marks, clk, rst, done_fire && found && !last_flag, occ[$past(pick_idx)])
  `FPFA_ASSERT_NXT(a_batch_clear, clk, rst, done_fire && last_flag, occ == '0)

endmodule

/* dv/tb_fixed_partition_fit_allocator.sv */
// self-checking testbench for the fixed partition fit allocator
// depends on fpfa_pkg and fixed_partition_fit_allocator; a shadow of the partition
// table predicts each grant, which is checked against the response channel
module tb_fixed_partition_fit_allocator;

  localparam int NUM_PARTS    = fpfa_pkg::NUM_PARTITIONS_DEF;
  localparam int IDX_W        = fpfa_pkg::FIELD_IDX_W;
  localparam int SIZE_W       = fpfa_pkg::FIELD_SIZE_W;
  localparam int DRAIN_CYCLES = NUM_PARTS + 8;
  localparam int LONG_HOLD    = 400;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [fpfa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fpfa_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            req_valid;
  logic                            req_stall;
  fpfa_pkg::req_item_t             req_item;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  fpfa_pkg::rsp_item_t             rsp_item;

  // shadow of the partition table and the registers
  logic [SIZE_W-1:0]            size_shadow [NUM_PARTS] = '{default: '0};
  logic                         occupied_shadow [NUM_PARTS] = '{default: 1'b0};
  logic                         fit_shadow = fpfa_pkg::FIT_BEST;
  logic [fpfa_pkg::PARTS_W-1:0] parts_shadow = fpfa_pkg::PARTS_RESET;

  fpfa_pkg::rsp_item_t grant_q [$];
  int                  mismatch_count = 0;

  // stall control
  logic idle_on;
  logic hold_tag = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   burst_left = 0;

  fixed_partition_fit_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // update the shadow for one accepted transaction and queue its grant, if any
  function automatic void predict_grant(input fpfa_pkg::req_item_t it);
    fpfa_pkg::rsp_item_t grant;
    int unsigned         count;
    int unsigned         j;
    int unsigned         left;
    int unsigned         best_left;
    bit                  found;
    grant     = '0;
    found     = 1'b0;
    best_left = 0;
    if (it.cmd == fpfa_pkg::CMD_LOAD) begin
      size_shadow[it.partition_index]     = it.partition_size;
      occupied_shadow[it.partition_index] = 1'b0;
      return;
    end
    // partition counts above the table size saturate
    count = (parts_shadow > NUM_PARTS) ? NUM_PARTS : parts_shadow;
    for (j = 0; j < count; j++) begin
      if (!occupied_shadow[j] && size_shadow[j] >= it.request_size) begin
        left = size_shadow[j] - it.request_size;
        if (fit_shadow == fpfa_pkg::FIT_FIRST) begin
          if (!found) begin
            found = 1'b1;
            grant.granted_index = IDX_W'(j);
          end
        end else if (!found || left < best_left) begin
          found = 1'b1;
          grant.granted_index = IDX_W'(j);
          best_left = left;
        end
      end
    end
    if (found) begin
      grant.granted      = 1'b1;
      grant.granted_size = size_shadow[grant.granted_index];
      occupied_shadow[grant.granted_index] = 1'b1;
    end
    // end of batch frees every partition
    if (it.last_request) begin
      occupied_shadow = '{default: 1'b0};
    end
    grant_q.push_back(grant);
  endfunction

  function automatic fpfa_pkg::req_item_t load_item(input int unsigned idx,
                                                    input int unsigned size,
                                                    input bit last);
    fpfa_pkg::req_item_t it;
    it = '0;
    it.cmd             = fpfa_pkg::CMD_LOAD;
    it.partition_index = IDX_W'(idx);
    it.partition_size  = SIZE_W'(size);
    it.last_request    = last;
    return it;
  endfunction

  function automatic fpfa_pkg::req_item_t alloc_item(input int unsigned request, input bit last);
    fpfa_pkg::req_item_t it;
    it = '0;
    it.cmd          = fpfa_pkg::CMD_ALLOC;
    it.request_size = SIZE_W'(request);
    it.last_request = last;
    return it;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(input int unsigned scale);
    case (scale)
      0: return SIZE_W'($urandom_range(0, 65535));
      1: return SIZE_W'($urandom_range(0, 31));
      2: return SIZE_W'($urandom_range(0, 4095));
      default: return SIZE_W'(65535 - $urandom_range(0, 31));
    endcase
  endfunction

  // offer one transaction, with an occasional gap in front, and wait for acceptance
  task automatic offer_transaction(input fpfa_pkg::req_item_t it);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_grant(it);
  endtask

  // stop sending until every grant is back and the block has gone quiet
  task automatic wait_for_grants();
    req_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write both registers while the block is idle; spare fit mode bits are random
  task automatic configure(input logic mode, input logic [fpfa_pkg::PARTS_W-1:0] parts);
    logic [fpfa_pkg::CFG_DATA_W-1:0] mode_word;
    mode_word    = fpfa_pkg::CFG_DATA_W'($urandom);
    mode_word[0] = mode;
    wait_for_grants();
    cfg_we    <= 1'b1;
    cfg_index <= fpfa_pkg::CFG_FIT_MODE;
    cfg_data  <= mode_word;
    @(posedge clk);
    fit_shadow = mode_word[0];
    cfg_index <= fpfa_pkg::CFG_PARTS_IN_USE;
    cfg_data  <= parts;
    @(posedge clk);
    parts_shadow = parts;
    cfg_we <= 1'b0;
  endtask

  // one batch: mostly allocations with a few loads, closed by a last request
  task automatic random_batch(inout int sent);
    fpfa_pkg::req_item_t it;
    int unsigned         n;
    int unsigned         scale;
    int unsigned         i;
    n     = $urandom_range(1, 24);
    scale = $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      it.cmd             = ($urandom_range(0, 4) == 0) ? fpfa_pkg::CMD_LOAD : fpfa_pkg::CMD_ALLOC;
      it.partition_index = IDX_W'($urandom_range(0, 15));
      it.partition_size  = pick_size(scale);
      it.request_size    = pick_size(scale);
      it.last_request    = ($urandom_range(0, 15) == 0);
      if (i == n - 1) begin
        it.last_request = 1'b1;
        if ($urandom_range(0, 9) != 0) begin
          it.cmd = fpfa_pkg::CMD_ALLOC;
        end
      end
      offer_transaction(it);
      sent++;
    end
  endtask

  // fill the whole table; the last load carries a last request, which has no effect
  task automatic test_load_extremes();
    int unsigned sizes [NUM_PARTS] = '{0, 65535, 1, 16'h8000, 16'h7fff, 100, 100, 16'h5555,
                                       16'haaaa, 50, 200, 99, 101, 1000, 100, 16'hfffe};
    int unsigned i;
    configure(fpfa_pkg::FIT_BEST, fpfa_pkg::PARTS_RESET);
    for (i = 0; i < NUM_PARTS; i++) begin
      offer_transaction(load_item(i, sizes[i], i == NUM_PARTS - 1));
    end
  endtask

  // zero request, ties to the lowest index, largest request, failure once taken
  task automatic test_best_fit();
    configure(fpfa_pkg::FIT_BEST, fpfa_pkg::PARTS_RESET);
    offer_transaction(alloc_item(0, 1'b0));
    offer_transaction(alloc_item(100, 1'b0));
    offer_transaction(alloc_item(100, 1'b0));
    offer_transaction(alloc_item(65535, 1'b0));
    offer_transaction(alloc_item(65535, 1'b1));
  endtask

  task automatic test_first_match();
    configure(fpfa_pkg::FIT_FIRST, fpfa_pkg::PARTS_RESET);
    offer_transaction(alloc_item(60, 1'b0));
    offer_transaction(alloc_item(60, 1'b0));
    offer_transaction(alloc_item(0, 1'b1));
  endtask

  // no partitions, a single one, and counts above the table size
  task automatic test_partition_count();
    configure(fpfa_pkg::FIT_BEST, 5'd0);
    offer_transaction(alloc_item(0, 1'b1));
    configure(fpfa_pkg::FIT_FIRST, 5'd1);
    offer_transaction(alloc_item(0, 1'b1));
    configure(fpfa_pkg::FIT_BEST, 5'd31);
    offer_transaction(alloc_item(16'hfffe, 1'b1));
    configure(fpfa_pkg::FIT_FIRST, 5'd17);
    offer_transaction(alloc_item(65535, 1'b1));
  endtask

  // random batches under a series of register settings
  task automatic test_random_phases();
    logic                         modes [10] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                                 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [fpfa_pkg::PARTS_W-1:0] parts [10] = '{5'd16, 5'd16, 5'd5, 5'd31, 5'd1,
                                                 5'd0, 5'd20, 5'd12, 5'd16, 5'd9};
    int                           sent;
    int unsigned                  p;
    for (p = 0; p < 10; p++) begin
      configure(modes[p], parts[p]);
      idle_on <= (p != 3);
      sent = 0;
      while (sent < 35) random_batch(sent);
    end
  endtask

  // the receiver holds off while transactions keep coming, so the input stalls
  task automatic test_receiver_hold();
    int sent;
    configure(fpfa_pkg::FIT_BEST, fpfa_pkg::PARTS_RESET);
    idle_on  <= 1'b1;
    hold_tag <= ~hold_tag;
    sent = 0;
    while (sent < 30) random_batch(sent);
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate_tail();
    int sent;
    idle_on <= 1'b0;
    configure(1'($urandom_range(0, 1)), fpfa_pkg::PARTS_RESET);
    sent = 0;
    while (sent < 60) random_batch(sent);
  endtask

  // receiver: a long hold when asked, otherwise random stall bursts
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = LONG_HOLD;
    end
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else if (burst_left != 0) begin
      rsp_stall <= 1'b1;
      burst_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rsp_stall <= 1'b1;
      burst_left = $urandom_range(1, 15) - 1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // compare each accepted result with the oldest expected grant
  always @(posedge clk) begin : grant_checker
    fpfa_pkg::rsp_item_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (grant_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: granted=%0d index=%0d size=%0d",
                   rsp_item.granted, rsp_item.granted_index, rsp_item.granted_size);
        end
      end else begin
        want = grant_q.pop_front();
        if (rsp_item.granted !== want.granted || rsp_item.granted_index !== want.granted_index
            || rsp_item.granted_size !== want.granted_size) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("grant mismatch: expected granted=%0d index=%0d size=%0d, got %0d %0d %0d",
                     want.granted, want.granted_index, want.granted_size,
                     rsp_item.granted, rsp_item.granted_index, rsp_item.granted_size);
          end
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    req_valid <= 1'b0;
    req_item  <= '0;
    idle_on   <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_load_extremes();
    test_best_fit();
    test_first_match();
    test_partition_count();
    test_random_phases();
    test_receiver_hold();
    test_full_rate_tail();
    wait_for_grants();
    mismatch_count += grant_q.size();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
